// ----- src/wsfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants shared by the weather-station frame decoder modules.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   // frame layout
   localparam logic [7:0] HDR_BYTE0       = 8'h24;
   localparam logic [7:0] HDR_BYTE1       = 8'h6B;
   localparam logic [3:0] POS_HDR0        = 4'd0;
   localparam logic [3:0] POS_HDR1        = 4'd1;
   localparam logic [3:0] POS_STORE_FIRST = 4'd2;
   localparam logic [3:0] POS_STORE_LAST  = 4'd13;
   localparam logic [3:0] POS_LAST        = 4'd14;
   localparam logic [3:0] POS_DONE        = 4'd15;
   localparam int         STORE_DEPTH     = 12;

   // scaling
   localparam logic signed [12:0] TEMP_OFFSET = 13'sd400;
   localparam logic [11:0]        SPEED_SCALE = 12'd14;
   localparam logic [14:0]        GUST_SCALE  = 15'd112;

   // port widths
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 168;

   // bytes 2..13 of a frame, index 0 holds byte 2
   typedef logic [STORE_DEPTH-1:0][7:0] frame_bytes_type;

   // capture stage to decode stage
   typedef struct packed {
      logic            done;
      frame_bytes_type bytes;
      logic [7:0]      last_byte;
   } capture_type;

   // result payload, last field in the lowest bits
   typedef struct packed {
      logic [6:0]         pad;
      logic signed [18:0] ended_day_rain;
      logic signed [12:0] max_temp;
      logic signed [12:0] min_temp;
      logic [23:0]        light_level;
      logic [15:0]        uv_index;
      logic signed [18:0] rain_today;
      logic [14:0]        wind_gust;
      logic [11:0]        wind_speed;
      logic [7:0]         humidity;
      logic signed [12:0] temperature;
      logic [8:0]         wind_dir;
   } rsp_data_type;

   typedef struct packed {
      rsp_data_type data;
      logic         day_ended;
   } result_type;

   // three times a 17-bit signed difference, as 19 bits
   function automatic logic signed [18:0] times_three(input logic signed [16:0] d);
      logic signed [18:0] d_ext;
      d_ext = {{2{d[16]}}, d};
      return d_ext + (d_ext <<< 1);
   endfunction

endpackage
`default_nettype wire

// ----- src/wsfd_frame_capture.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_frame_capture
// Tracks the byte position, checks the header and stores frame bytes.
// ----------------------------------------------------------------------------
module wsfd_frame_capture (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_en,
   input  wire logic [7:0]            rx_byte,
   input  wire logic                  frame_start,
   output wsfd_pkg::capture_type      cap
);
   import wsfd_pkg::*;

   logic [3:0]      pos_ff, pos_in;
   logic            hdr_ok_ff, hdr_ok_in;
   frame_bytes_type store_ff;
   logic [3:0]      pos_eff;
   logic [3:0]      wr_idx;
   logic            wr_en;

   // position and header check for this item
   always_comb begin
      pos_eff   = frame_start ? POS_HDR0 : pos_ff;
      hdr_ok_in = hdr_ok_ff;
      pos_in    = pos_ff;
      wr_en     = 1'b0;
      wr_idx    = pos_eff - POS_STORE_FIRST;
      cap.done  = 1'b0;
      if (pos_eff != POS_DONE) begin
         if (pos_eff == POS_HDR0) begin
            hdr_ok_in = (rx_byte == HDR_BYTE0);
         end else if (pos_eff == POS_HDR1) begin
            hdr_ok_in = hdr_ok_ff && (rx_byte == HDR_BYTE1);
         end else if (pos_eff inside {[POS_STORE_FIRST:POS_STORE_LAST]}) begin
            wr_en = 1'b1;
         end
         if (pos_eff == POS_LAST) begin
            pos_in   = POS_DONE;
            cap.done = hdr_ok_in;
         end else begin
            pos_in = pos_eff + 4'd1;
         end
      end else begin
         pos_in = pos_eff;
      end
      cap.bytes     = store_ff;
      cap.last_byte = rx_byte;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_HDR0;
         hdr_ok_ff <= 1'b0;
      end else if (step_en) begin
         pos_ff    <= pos_in;
         hdr_ok_ff <= hdr_ok_in;
      end
   end

   // frame byte store
   always_ff @(posedge clock) begin
      if (step_en && wr_en) begin
         store_ff[wr_idx] <= rx_byte;
      end
   end

endmodule
`default_nettype wire

// ----- src/wsfd_day_stats.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_day_stats
// Decodes a completed frame and keeps daily min/max and the rain base.
// ----------------------------------------------------------------------------
module wsfd_day_stats (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  commit,
   input  wire wsfd_pkg::capture_type cap,
   input  wire logic [4:0]            day_of_month,
   output wsfd_pkg::result_type       result
);
   import wsfd_pkg::*;

   logic               has_minmax_ff;
   logic signed [12:0] min_ff, min_in;
   logic signed [12:0] max_ff, max_in;
   logic               has_day_ff;
   logic [4:0]         day_ff, day_in;
   logic               has_base_ff;
   logic [15:0]        base_ff, base_in;

   logic [11:0]        temp_raw;
   logic signed [12:0] temp;
   logic signed [12:0] min_eff, max_eff, min_new, max_new;
   logic [4:0]         day_eff;
   logic               ended, rebase;
   logic [15:0]        count;
   logic signed [16:0] diff_old, diff_new;

   // field extraction and scaling
   always_comb begin
      temp_raw = {cap.bytes[1][3:0], cap.bytes[2]};
      temp     = $signed({1'b0, temp_raw}) - TEMP_OFFSET;
      count    = {cap.bytes[6], cap.bytes[7]};
   end

   // running extremes, day change and rebase
   always_comb begin
      min_eff  = has_minmax_ff ? min_ff : temp;
      max_eff  = has_minmax_ff ? max_ff : temp;
      min_new  = (min_eff > temp) ? temp : min_eff;
      max_new  = (max_eff < temp) ? temp : max_eff;
      day_eff  = has_day_ff ? day_ff : day_of_month;
      ended    = (day_of_month != day_eff);
      rebase   = ended || !has_base_ff;
      min_in   = ended ? temp : min_new;
      max_in   = ended ? temp : max_new;
      day_in   = rebase ? day_of_month : day_eff;
      base_in  = rebase ? count : base_ff;
      diff_old = $signed({1'b0, count}) - $signed({1'b0, base_ff});
      diff_new = $signed({1'b0, count}) - $signed({1'b0, base_in});
   end

   // result fields
   always_comb begin
      result.data.pad            = '0;
      result.data.wind_dir       = {cap.bytes[1][7], cap.bytes[0]};
      result.data.temperature    = temp;
      result.data.humidity       = cap.bytes[3];
      result.data.wind_speed     = 12'(cap.bytes[4]) * SPEED_SCALE;
      result.data.wind_gust      = 15'(cap.bytes[5]) * GUST_SCALE;
      result.data.rain_today     = times_three(diff_new);
      result.data.uv_index       = {cap.bytes[8], cap.bytes[9]};
      result.data.light_level    = {cap.bytes[10], cap.bytes[11], cap.last_byte};
      result.data.min_temp       = ended ? min_new : 13'sd0;
      result.data.max_temp       = ended ? max_new : 13'sd0;
      result.data.ended_day_rain = ended ? times_three(diff_old) : 19'sd0;
      result.day_ended           = ended;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         has_minmax_ff <= 1'b0;
         min_ff        <= '0;
         max_ff        <= '0;
         has_day_ff    <= 1'b0;
         day_ff        <= '0;
         has_base_ff   <= 1'b0;
         base_ff       <= '0;
      end else if (commit) begin
         has_minmax_ff <= 1'b1;
         min_ff        <= min_in;
         max_ff        <= max_in;
         has_day_ff    <= 1'b1;
         day_ff        <= day_in;
         has_base_ff   <= 1'b1;
         base_ff       <= base_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/weather_station_frame_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weather_station_frame_decoder
// Decodes 15-byte weather-station frames into scaled sensor readings.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one received byte per item; req_tuser flags the first byte of
//   a frame, req_tdata also carries the current day of month.
//   rsp channel: one item per completed frame with a good 0x24 0x6B header;
//   rsp_tuser flags an item that closed a day (min/max and day rain valid).
// Path: an accepted byte enters the input register; it is decoded as it leaves
//   that register and, on the last byte of a good frame, the result is loaded
//   into the output register, which drives rsp_tvalid.
// Throughput: one byte per cycle while rsp is not held, set by the single decode
//   step between the input register and the output register.
// Reset: synchronous; clears byte position, header flag, day, extremes and
//   rain base. Bytes before any frame start count as a frame beginning.
// Stall: while rsp is held, the input register holds its byte and req_tready
//   drops once it is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module weather_station_frame_decoder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // [7:0] rx_byte, [12:8] day_of_month, [15:13] zero
   input  wire logic [wsfd_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [0] frame_start
   input  wire logic                               req_tuser,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [8:0] wind_dir, [21:9] temperature, [29:22] humidity, [41:30] wind_speed,
   // [56:42] wind_gust, [75:57] rain_today, [91:76] uv_index,
   // [115:92] light_level, [128:116] min_temp, [141:129] max_temp,
   // [160:142] ended_day_rain, [167:161] zero
   output      logic [wsfd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [0] day_ended
   output      logic                               rsp_tuser
);
   import wsfd_pkg::*;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   logic [4:0]  in_day_ff;
   logic        advance;
   logic        commit;

   logic        out_valid_ff, out_valid_in;
   result_type  out_res_ff;

   capture_type cap;
   result_type  result;

   // handshake: the input register drains whenever the output slot is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign commit     = advance && cap.done;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata[7:0];
         in_start_ff <= req_tuser;
         in_day_ff   <= req_tdata[12:8];
      end
   end

   wsfd_frame_capture u_capture (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .rx_byte     (in_byte_ff),
      .frame_start (in_start_ff),
      .cap         (cap)
   );

   wsfd_day_stats u_stats (
      .clock        (clock),
      .reset        (reset),
      .commit       (commit),
      .cap          (cap),
      .day_of_month (in_day_ff),
      .result       (result)
   );

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (commit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         out_res_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_res_ff.data;
   assign rsp_tuser  = out_res_ff.day_ended;

endmodule
`default_nettype wire

// ----- src/wsfd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_checker
// Port-level checks for the weather-station frame decoder.
// ----------------------------------------------------------------------------
module wsfd_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [167:0] rsp_tdata,
   input wire logic         rsp_tuser
);

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   // no result straight after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item valid after reset");

   // closing fields stay zero unless a day ended
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[160:116] == '0)
      else $error("day-close fields set without day change");

   // with an empty output slot the block takes a byte
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // padding bits are zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[167:161] == '0)
      else $error("result padding not zero");

endmodule

bind weather_station_frame_decoder wsfd_checker u_wsfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the weather-station frame decoder. A table of
// directed frames runs first, then random frames under several patterns of
// source gaps and sink back-pressure. Every accepted byte goes through a
// behavioral decoder that predicts the result items; the results coming out
// of the block are compared field by field in order.
// ----------------------------------------------------------------------------
module testbench;
   import wsfd_pkg::*;

   localparam int HOLD_CYCLES      = 300;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int DRAIN_CYCLES     = 10;
   localparam int FRAMES_PER_PHASE = 5;
   localparam int NUM_PHASES       = 5;
   localparam int MAX_FRAME_BYTES  = 20;

   // how a directed frame is checked
   typedef enum {CHK_MODEL, CHK_GIVEN, CHK_SILENT} check_kind_type;

   typedef struct {
      int             n_bytes;
      bit             first_start;
      logic [4:0]     day;
      logic [7:0]     hdr0;
      logic [7:0]     hdr1;
      logic [7:0]     fill;
      logic [7:0]     step;
      check_kind_type check;
      result_type     given;
   } frame_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // [7:0] rx_byte, [12:8] day_of_month, [15:13] zero
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // [0] frame_start
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [8:0] wind_dir .. [160:142] ended_day_rain, see rsp_data_type
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // [0] day_ended
   logic rsp_tuser;

   // decoder state mirrored by the bench
   logic [3:0]  dec_pos = '0;
   bit          dec_hdr_ok = 1'b0;
   logic [7:0]  dec_bytes [0:12];
   bit          dec_has_minmax = 1'b0;
   int          dec_min = 0;
   int          dec_max = 0;
   bit          dec_has_day = 1'b0;
   logic [4:0]  dec_day = '0;
   bit          dec_has_base = 1'b0;
   logic [15:0] dec_rain_base = '0;

   result_type    pending_results [$];
   frame_row_type frame_table [$];
   logic [7:0]    frame_buf [0:MAX_FRAME_BYTES-1];
   logic [4:0]    stim_day = 5'd1;
   int            send_idle_pct = 0;
   int            rsp_stall_pct = 0;
   int            hold_asked = 0;
   int            hold_served = 0;
   int            fail_count = 0;
   int            quiet_cycles = 0;
   int            phase_send_idle [NUM_PHASES] = '{0, 86, 0, 25, 0};
   int            phase_rsp_stall [NUM_PHASES] = '{0, 0, 86, 25, 0};

   weather_station_frame_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch(name, got, want);
      end
   endtask

   function automatic result_type make_result(input int wdir, input int temp, input int hum,
                                              input int spd, input int gust, input int rain,
                                              input int uv, input int light, input int lo,
                                              input int hi, input bit ended, input int erain);
      result_type r;
      r = '0;
      r.data.wind_dir       = wdir[8:0];
      r.data.temperature    = temp[12:0];
      r.data.humidity       = hum[7:0];
      r.data.wind_speed     = spd[11:0];
      r.data.wind_gust      = gust[14:0];
      r.data.rain_today     = rain[18:0];
      r.data.uv_index       = uv[15:0];
      r.data.light_level    = light[23:0];
      r.data.min_temp       = lo[12:0];
      r.data.max_temp       = hi[12:0];
      r.data.ended_day_rain = erain[18:0];
      r.day_ended           = ended;
      return r;
   endfunction

   // behavioral decoder: one accepted byte in, at most one result item out
   task automatic decode_byte(input logic [7:0] b, input bit st, input logic [4:0] day,
                              output bit produced, output result_type res);
      int          temp;
      int          rain_now;
      int          ended_rain;
      int          close_min;
      int          close_max;
      logic [15:0] count;
      bit          ended;
      produced   = 1'b0;
      res        = '0;
      ended      = 1'b0;
      ended_rain = 0;
      close_min  = 0;
      close_max  = 0;
      if (st) begin
         dec_pos = POS_HDR0;
      end
      if (dec_pos != POS_DONE) begin
         // header check or payload capture
         if (dec_pos == POS_HDR0) begin
            dec_hdr_ok = (b == HDR_BYTE0);
         end else if (dec_pos == POS_HDR1) begin
            dec_hdr_ok = dec_hdr_ok && (b == HDR_BYTE1);
         end else begin
            dec_bytes[dec_pos - POS_STORE_FIRST] = b;
         end
         if (dec_pos != POS_LAST) begin
            dec_pos = dec_pos + 4'd1;
         end else begin
            dec_pos = POS_DONE;
            if (dec_hdr_ok) begin
               temp = int'({dec_bytes[1][3:0], dec_bytes[2]}) - int'(TEMP_OFFSET);
               // running daily extremes
               if (!dec_has_minmax) begin
                  dec_min        = temp;
                  dec_max        = temp;
                  dec_has_minmax = 1'b1;
               end
               if (dec_min > temp) dec_min = temp;
               if (dec_max < temp) dec_max = temp;
               count = {dec_bytes[6], dec_bytes[7]};
               // day rollover closes extremes and rain
               if (!dec_has_day) begin
                  dec_day     = day;
                  dec_has_day = 1'b1;
               end
               if (day != dec_day) begin
                  ended        = 1'b1;
                  ended_rain   = 3 * (int'(count) - int'(dec_rain_base));
                  close_min    = dec_min;
                  close_max    = dec_max;
                  dec_min      = temp;
                  dec_max      = temp;
                  dec_has_base = 1'b0;
               end
               if (!dec_has_base) begin
                  dec_day       = day;
                  dec_has_base  = 1'b1;
                  dec_rain_base = count;
               end
               rain_now = 3 * (int'(count) - int'(dec_rain_base));
               // scaled fields
               res.data.wind_dir       = {dec_bytes[1][7], dec_bytes[0]};
               res.data.temperature    = temp[12:0];
               res.data.humidity       = dec_bytes[3];
               res.data.wind_speed     = {4'd0, dec_bytes[4]} * SPEED_SCALE;
               res.data.wind_gust      = {7'd0, dec_bytes[5]} * GUST_SCALE;
               res.data.rain_today     = rain_now[18:0];
               res.data.uv_index       = {dec_bytes[8], dec_bytes[9]};
               res.data.light_level    = {dec_bytes[10], dec_bytes[11], dec_bytes[12]};
               res.data.min_temp       = close_min[12:0];
               res.data.max_temp       = close_max[12:0];
               res.data.ended_day_rain = ended_rain[18:0];
               res.day_ended           = ended;
               produced                = 1'b1;
            end
         end
      end
   endtask

   // offer one byte item, with random source gaps, and wait for acceptance
   task automatic send_byte(input logic [7:0] b, input bit st, input logic [4:0] day,
                            output bit produced, output result_type res);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, day, b};
      req_tuser  <= st;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_byte(b, st, day, produced, res);
   endtask

   // send frame_buf; the day only matters on the last byte of a frame
   task automatic send_frame(input int n, input bit first_start, input logic [4:0] day,
                             input check_kind_type chk, input result_type given);
      bit         produced;
      result_type predicted;
      logic [4:0] byte_day;
      for (int k = 0; k < n; k++) begin
         if (k == int'(POS_LAST)) begin
            byte_day = day;
         end else begin
            byte_day = 5'($urandom_range(0, 31));
         end
         send_byte(frame_buf[k], (k == 0) ? first_start : 1'b0, byte_day, produced, predicted);
         case (chk)
            CHK_MODEL: begin
               if (produced) pending_results.push_back(predicted);
            end
            CHK_GIVEN: begin
               if (k == int'(POS_LAST)) pending_results.push_back(given);
            end
            default: begin
            end
         endcase
      end
   endtask

   task automatic add_row(input int n, input bit st, input logic [4:0] day,
                          input logic [7:0] h0, input logic [7:0] h1,
                          input logic [7:0] fill, input logic [7:0] step,
                          input check_kind_type chk, input result_type given);
      frame_row_type row;
      row.n_bytes     = n;
      row.first_start = st;
      row.day         = day;
      row.hdr0        = h0;
      row.hdr1        = h1;
      row.fill        = fill;
      row.step        = step;
      row.check       = chk;
      row.given       = given;
      frame_table.push_back(row);
   endtask

   // sink: random back-pressure, or a long hold-off when one is asked for
   always begin
      @(posedge clock);
      if (hold_asked != hold_served) begin
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_served = hold_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // compare each result item with the oldest prediction
   always @(posedge clock) begin : result_check
      rsp_data_type got;
      result_type   want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", 1, 0);
         end else begin
            want = pending_results.pop_front();
            got  = rsp_tdata;
            check_field("wind_dir", int'(got.wind_dir), int'(want.data.wind_dir));
            check_field("temperature", int'($signed(got.temperature)),
                        int'($signed(want.data.temperature)));
            check_field("humidity", int'(got.humidity), int'(want.data.humidity));
            check_field("wind_speed", int'(got.wind_speed), int'(want.data.wind_speed));
            check_field("wind_gust", int'(got.wind_gust), int'(want.data.wind_gust));
            check_field("rain_today", int'($signed(got.rain_today)),
                        int'($signed(want.data.rain_today)));
            check_field("uv_index", int'(got.uv_index), int'(want.data.uv_index));
            check_field("light_level", int'(got.light_level), int'(want.data.light_level));
            check_field("min_temp", int'($signed(got.min_temp)),
                        int'($signed(want.data.min_temp)));
            check_field("max_temp", int'($signed(got.max_temp)),
                        int'($signed(want.data.max_temp)));
            check_field("day_ended", int'(rsp_tuser), int'(want.day_ended));
            check_field("ended_day_rain", int'($signed(got.ended_day_rain)),
                        int'($signed(want.data.ended_day_rain)));
         end
      end
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("weather_station_frame_decoder regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      int draw;
      int good_frames;
      int n;
      bit st;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed frames
      add_row(15, 1'b0, 5'd5, HDR_BYTE0, HDR_BYTE1, 8'h00, 8'h00, CHK_GIVEN,
              make_result(0, -400, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0));
      add_row(15, 1'b1, 5'd5, HDR_BYTE0, HDR_BYTE1, 8'hFF, 8'h00, CHK_GIVEN,
              make_result(511, 3695, 255, 3570, 28560, 196605, 65535, 16777215,
                          0, 0, 1'b0, 0));
      add_row(15, 1'b1, 5'd6, HDR_BYTE0, HDR_BYTE1, 8'hFF, 8'h00, CHK_GIVEN,
              make_result(511, 3695, 255, 3570, 28560, 0, 65535, 16777215,
                          -400, 3695, 1'b1, 196605));
      add_row(15, 1'b1, 5'd6, HDR_BYTE0, HDR_BYTE1, 8'h00, 8'h00, CHK_GIVEN,
              make_result(0, -400, 0, 0, 0, -196605, 0, 0, 0, 0, 1'b0, 0));
      add_row(15, 1'b1, 5'd6, 8'h25, HDR_BYTE1, 8'h00, 8'h00, CHK_SILENT, '0);
      add_row(15, 1'b1, 5'd6, HDR_BYTE0, 8'h6A, 8'h00, 8'h00, CHK_SILENT, '0);
      add_row(9, 1'b1, 5'd6, HDR_BYTE0, HDR_BYTE1, 8'h11, 8'h03, CHK_SILENT, '0);
      add_row(20, 1'b1, 5'd7, HDR_BYTE0, HDR_BYTE1, 8'h5A, 8'h1D, CHK_MODEL, '0);
      add_row(3, 1'b0, 5'd7, HDR_BYTE0, HDR_BYTE1, 8'h00, 8'h00, CHK_SILENT, '0);
      add_row(15, 1'b1, 5'd0, HDR_BYTE0, HDR_BYTE1, 8'h80, 8'h07, CHK_MODEL, '0);
      add_row(15, 1'b1, 5'd31, HDR_BYTE0, HDR_BYTE1, 8'h3C, 8'hE3, CHK_MODEL, '0);
      add_row(15, 1'b1, 5'd31, HDR_BYTE0, HDR_BYTE1, 8'hC7, 8'h41, CHK_MODEL, '0);
      add_row(15, 1'b1, 5'd30, HDR_BYTE0, HDR_BYTE1, 8'h00, 8'h01, CHK_MODEL, '0);

      foreach (frame_table[i]) begin
         frame_buf[0] = frame_table[i].hdr0;
         frame_buf[1] = frame_table[i].hdr1;
         for (int k = 2; k < MAX_FRAME_BYTES; k++) begin
            frame_buf[k] = 8'(frame_table[i].fill + frame_table[i].step * (k - 2));
         end
         send_frame(frame_table[i].n_bytes, frame_table[i].first_start, frame_table[i].day,
                    frame_table[i].check, frame_table[i].given);
      end
      stim_day = 5'd30;

      // random frames, one traffic pattern per phase
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct = phase_send_idle[phase];
         rsp_stall_pct = phase_rsp_stall[phase];
         if (phase == NUM_PHASES - 1) begin
            // sink holds off while the source keeps offering
            hold_asked = hold_asked + 1;
         end
         good_frames = 0;
         while (good_frames < FRAMES_PER_PHASE) begin
            for (int k = 0; k < MAX_FRAME_BYTES; k++) begin
               frame_buf[k] = 8'($urandom_range(0, 255));
            end
            frame_buf[0] = HDR_BYTE0;
            frame_buf[1] = HDR_BYTE1;
            if ($urandom_range(0, 99) < 20) begin
               stim_day = 5'($urandom_range(0, 31));
            end
            st   = 1'b1;
            n    = int'(POS_LAST) + 1;
            draw = $urandom_range(0, 99);
            if (draw < 75) begin
               good_frames++;
            end else if (draw < 85) begin
               // long frame, trailing bytes ignored
               n = $urandom_range(16, MAX_FRAME_BYTES);
               good_frames++;
            end else if (draw < 92) begin
               // broken header
               if ($urandom_range(0, 1) == 1) begin
                  frame_buf[0] = 8'($urandom_range(0, 255));
               end else begin
                  frame_buf[1] = 8'($urandom_range(0, 255));
               end
            end else if (draw < 97) begin
               // cut short by the next frame start
               n = $urandom_range(1, 14);
            end else begin
               // stray bytes with no frame start
               n  = $urandom_range(1, 5);
               st = 1'b0;
            end
            send_frame(n, st, stim_day, CHK_MODEL, '0);
         end
      end
      req_tvalid <= 1'b0;

      // drain
      rsp_stall_pct = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("weather_station_frame_decoder regression: pass");
      end else begin
         $display("weather_station_frame_decoder regression: fail");
      end
      $finish;
   end

endmodule
